@@ sv/slcd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, command codes and segment patterns for the segment LCD frame composer.
// No dependencies; every other file imports this package.
package slcd_pkg;

	localparam logic [3:0] MODE_BIG     = 4'd0;
	localparam logic [3:0] MODE_SMALL   = 4'd1;
	localparam logic [3:0] MODE_UNIT    = 4'd2;
	localparam logic [3:0] MODE_FACE    = 4'd3;
	localparam logic [3:0] MODE_RADIO   = 4'd4;
	localparam logic [3:0] MODE_BATTERY = 4'd5;
	localparam logic [3:0] MODE_ERROR   = 4'd6;
	localparam logic [3:0] MODE_OTA     = 4'd7;
	localparam logic [3:0] MODE_RESET   = 4'd8;
	localparam logic [3:0] MODE_REFRESH = 4'd9;

	localparam logic [7:0] SYM_H      = 8'h67;
	localparam logic [7:0] SYM_I      = 8'h40;
	localparam logic [7:0] SYM_L      = 8'hE0;
	localparam logic [7:0] SYM_O      = 8'hC6;
	localparam logic [7:0] SYM_E      = 8'hF2;
	localparam logic [7:0] SYM_A      = 8'hD7;
	localparam logic [7:0] SYM_T      = 8'hE2;
	localparam logic [7:0] DIGIT_ZERO = 8'hF5;
	localparam logic [7:0] SEG_MINUS  = 8'h02;
	localparam logic [7:0] SEG_ONE    = 8'h08;
	localparam logic [7:0] SEG_POINT  = 8'h08;
	localparam logic [7:0] BLINK_FLASH = 8'hF2;
	localparam logic [7:0] BLINK_OFF   = 8'hF0;

	localparam int FRAME_BYTES = 6;

	// Command after decode: payload bytes prepared by the front end.
	typedef struct packed {
		logic [3:0] mode;
		logic [2:0] unit_code;
		logic       flag;
		logic [2:0] face;
		logic [7:0] p0;
		logic [7:0] p1;
		logic [7:0] p2;
		logic       big_num;   // big number shown as digits: clear byte 5
	} cmd_t;

	typedef struct packed {
		logic [FRAME_BYTES-1:0][7:0] frame;
		logic [7:0]                  blink;
	} res_t;

	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'hF5;
			4'd1: s = 8'h05;
			4'd2: s = 8'hD3;
			4'd3: s = 8'h97;
			4'd4: s = 8'h27;
			4'd5: s = 8'hB6;
			4'd6: s = 8'hF6;
			4'd7: s = 8'h15;
			4'd8: s = 8'hF7;
			4'd9: s = 8'hB7;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

@@ sv/slcd_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts commands, classifies numbers and builds digit segment bytes.
// Two pipeline stages; depends on slcd_pkg.
module slcd_front import slcd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [3:0]         mode,
	input  logic signed [15:0] number,
	input  logic [2:0]         unit_code,
	input  logic               flag,
	input  logic [2:0]         face,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output cmd_t               cmd
);

	typedef struct packed {
		logic [3:0]  mode;
		logic [2:0]  unit_code;
		logic        flag;
		logic [2:0]  face;
		logic [10:0] mag;
		logic        hi;
		logic        lo;
		logic        point;
		logic        neg;
	} s1_t;

	logic  v_s1, v_s2;
	s1_t   d_s1;
	cmd_t  d_s2;
	logic  adv1, adv2;

	assign adv2 = !v_s2 || cmd_ready;
	assign adv1 = !v_s1 || adv2;
	assign full = !adv1;

	// stage 1: magnitude, rounding and range class
	logic [15:0] mag;
	logic [15:0] mag_p5;
	logic [31:0] rnd_prod;
	logic        is_big;
	s1_t         n_s1;

	always_comb begin
		mag      = number[15] ? 16'(-number) : 16'(number);
		mag_p5   = {1'b0, mag[14:0]} + 16'd5;
		rnd_prod = 32'(mag_p5) * 32'd52429;
		is_big   = (mode == MODE_BIG);
		n_s1.mode      = mode;
		n_s1.unit_code = unit_code;
		n_s1.flag      = flag;
		n_s1.face      = face;
		n_s1.neg       = number[15];
		n_s1.point     = (number >= -16'sd99) && (number <= 16'sd1999);
		n_s1.hi        = is_big ? (number > 16'sd19995) : (number > 16'sd99);
		n_s1.lo        = is_big ? (number < -16'sd995) : (number < -16'sd9);
		n_s1.mag       = (is_big && !n_s1.point) ? rnd_prod[29:19] : mag[10:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && push) begin
			d_s1 <= n_s1;
		end
	end

	// stage 2: decimal digits and segment bytes
	logic [27:0] p10;
	logic [23:0] p100;
	logic [7:0]  q10;
	logic [4:0]  q100;
	logic [10:0] ones_w;
	logic [7:0]  tens_w;
	logic [3:0]  ones, tens, hund;
	cmd_t        n_s2;

	always_comb begin
		p10    = 28'(d_s1.mag) * 28'd52429;
		p100   = 24'(d_s1.mag) * 24'd5243;
		q10    = p10[26:19];
		q100   = p100[23:19];
		ones_w = d_s1.mag - 11'(q10) * 11'd10;
		tens_w = q10 - 8'(q100) * 8'd10;
		ones   = ones_w[3:0];
		tens   = tens_w[3:0];
		if (q100 >= 5'd20) begin
			hund = 4'(q100 - 5'd20);
		end else if (q100 >= 5'd10) begin
			hund = 4'(q100 - 5'd10);
		end else begin
			hund = q100[3:0];
		end

		n_s2.mode      = d_s1.mode;
		n_s2.unit_code = d_s1.unit_code;
		n_s2.flag      = d_s1.flag;
		n_s2.face      = d_s1.face;
		n_s2.p0        = 8'h00;
		n_s2.p1        = 8'h00;
		n_s2.p2        = 8'h00;
		n_s2.big_num   = 1'b0;
		if (d_s1.mode == MODE_BIG) begin
			if (d_s1.hi) begin
				n_s2.p0 = SYM_H;
				n_s2.p1 = SYM_I;
			end else if (d_s1.lo) begin
				n_s2.p0 = SYM_L;
				n_s2.p1 = SYM_O;
			end else begin
				n_s2.big_num = 1'b1;
				if (d_s1.neg && d_s1.mag != 11'd0) n_s2.p0 = SEG_MINUS;
				if (d_s1.mag > 11'd999) n_s2.p0 = n_s2.p0 | SEG_ONE;
				if (d_s1.mag > 11'd99) n_s2.p0 = n_s2.p0 | seg_of(hund);
				n_s2.p1 = d_s1.point ? SEG_POINT : 8'h00;
				n_s2.p1 = n_s2.p1 | ((d_s1.mag > 11'd9) ? seg_of(tens) : DIGIT_ZERO);
				n_s2.p2 = seg_of(ones);
			end
		end else begin
			// small number bytes; other modes ignore p0/p1
			n_s2.p1 = d_s1.flag ? SEG_POINT : 8'h00;
			if (d_s1.hi) begin
				n_s2.p0 = SYM_H;
				n_s2.p1 = n_s2.p1 | SYM_I;
			end else if (d_s1.lo) begin
				n_s2.p0 = SYM_L;
				n_s2.p1 = n_s2.p1 | SYM_O;
			end else begin
				if (d_s1.neg) n_s2.p0 = SEG_MINUS;
				if (d_s1.mag > 11'd9) n_s2.p0 = n_s2.p0 | seg_of(tens);
				n_s2.p1 = n_s2.p1 | seg_of(ones);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			d_s2 <= n_s2;
		end
	end

	assign cmd_valid = v_s2;
	assign cmd       = d_s2;

endmodule

@@ sv/slcd_cmd_fifo.sv @@
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the frame engine.
// Depends on slcd_pkg for cmd_t.
module slcd_cmd_fifo import slcd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic wr_ready,
	input  logic rd_en,
	output logic rd_valid,
	output cmd_t rd_data
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr, do_rd;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && wr_ready;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= !wr_ptr_q;
			if (do_rd) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(do_wr) - 2'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ sv/slcd_back.sv @@
`timescale 1ns / 1ps
// Frame engine: applies commands to the working frame, decides refreshes and
// queues the frames that are sent. Depends on slcd_pkg.
module slcd_back import slcd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic display_disabled,
	input  logic cmd_valid,
	output logic cmd_take,
	input  cmd_t cmd,
	output logic res_empty,
	input  logic res_pop,
	output res_t res
);

	logic [FRAME_BYTES-1:0][7:0] wf_q, sf_q;
	logic [7:0]                  blink_q;

	res_t       rmem_q [2];
	logic       rwr_ptr_q, rrd_ptr_q;
	logic [1:0] rcount_q;

	logic [FRAME_BYTES-1:0][7:0] nwf;
	logic [7:0]                  nblink, blink_use;
	logic                        is_refresh, emit, do_pop;
	logic [7:0]                  unit3;

	assign cmd_take = cmd_valid && (rcount_q != 2'd2);

	always_comb begin
		nwf        = wf_q;
		blink_use  = blink_q;
		is_refresh = 1'b0;
		unit3      = (wf_q[3] & 8'h3F) | {cmd.unit_code[1], cmd.unit_code[0], 6'b0};
		unique case (cmd.mode)
			MODE_BIG: begin
				nwf[0] = cmd.p0;
				nwf[1] = cmd.p1;
				nwf[2] = {4'b0, cmd.unit_code[2], 3'b0} | cmd.p2;
				nwf[3] = unit3;
				if (cmd.big_num) nwf[5] = 8'h00;
			end
			MODE_SMALL: begin
				nwf[4] = (wf_q[4] & 8'h08) | cmd.p0;
				nwf[5] = cmd.p1;
			end
			MODE_UNIT: begin
				nwf[3]    = unit3;
				nwf[2][3] = cmd.unit_code[2];
			end
			MODE_FACE: begin
				nwf[3] = (wf_q[3] & 8'hEC) | {3'b0, cmd.face[2], 2'b0, cmd.face[1:0]};
			end
			MODE_RADIO: begin
				nwf[4][3] = cmd.flag;
			end
			MODE_BATTERY: begin
				nwf[3][5] = cmd.flag;
			end
			MODE_ERROR: begin
				nwf[0] = SYM_E;
				nwf[1] = SYM_E;
				nwf[2] = 8'h00;
				nwf[3] = wf_q[3] & 8'h20;
				nwf[4] = (wf_q[4] & 8'h08) | SYM_E;
				nwf[5] = SYM_E;
			end
			MODE_OTA: begin
				nwf[0]     = SYM_O;
				nwf[1]     = SYM_T;
				nwf[2]     = SYM_A;
				nwf[3]     = wf_q[3] & 8'h20;
				nwf[4]     = 8'h08;
				nwf[5]     = 8'h00;
				blink_use  = BLINK_FLASH;
				is_refresh = 1'b1;
			end
			MODE_RESET: begin
				nwf[0]     = SYM_O;
				nwf[1]     = SYM_O;
				nwf[2]     = SYM_O;
				nwf[3]     = wf_q[3] & 8'h20;
				nwf[4]     = wf_q[4] & 8'h08;
				nwf[5]     = 8'h00;
				blink_use  = BLINK_FLASH;
				is_refresh = 1'b1;
			end
			MODE_REFRESH: begin
				is_refresh = 1'b1;
			end
			default: begin
			end
		endcase
		emit   = is_refresh && !display_disabled && (nwf != sf_q);
		nblink = blink_use;
		if (emit && blink_use != 8'h00) begin
			nblink = (blink_use > BLINK_OFF) ? BLINK_OFF : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wf_q    <= {FRAME_BYTES{8'hFF}};
			sf_q    <= '0;
			blink_q <= 8'h00;
		end else if (cmd_take) begin
			wf_q    <= nwf;
			blink_q <= nblink;
			if (emit) sf_q <= nwf;
		end
	end

	// result queue
	assign res_empty = (rcount_q == 2'd0);
	assign res       = rmem_q[rrd_ptr_q];
	assign do_pop    = res_pop && !res_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwr_ptr_q <= 1'b0;
			rrd_ptr_q <= 1'b0;
			rcount_q  <= 2'd0;
		end else begin
			if (cmd_take && emit) rwr_ptr_q <= !rwr_ptr_q;
			if (do_pop) rrd_ptr_q <= !rrd_ptr_q;
			rcount_q <= rcount_q + 2'(cmd_take && emit) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take && emit) begin
			rmem_q[rwr_ptr_q].frame <= nwf;
			rmem_q[rwr_ptr_q].blink <= blink_use;
		end
	end

endmodule

@@ sv/segment_lcd_frame_composer.sv @@
`timescale 1ns / 1ps
// Top level of the segment LCD frame composer: front end, command queue,
// frame engine and the display enable register. Depends on slcd_pkg and all slcd_* modules.
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------
//  command   | push / full        | mode, number, unit_code, flag, face
//  frame out | empty / pop        | seg_byte0..seg_byte5, blink_command
//  config    | cfg_wen            | cfg_wdata (display_disabled)
//
// While full is low one command per cycle is sustained; a command passes the two
// front-end stages (digit extraction by reciprocal multiply) and the command queue,
// and the frame engine applies it. A frame that a refresh sends is registered in the
// result queue after the front stages and the command queue, and shows from there.
// Reset sets the working frame to all ones, the shown frame and blink byte to zero.
// Each side stalls on its own: a two-entry queue holds commands and another
// holds sent frames; full rises only when both queues and the front stages fill.
module segment_lcd_frame_composer import slcd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [3:0]         mode,
	input  logic signed [15:0] number,
	input  logic [2:0]         unit_code,
	input  logic               flag,
	input  logic [2:0]         face,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         seg_byte0,
	output logic [7:0]         seg_byte1,
	output logic [7:0]         seg_byte2,
	output logic [7:0]         seg_byte3,
	output logic [7:0]         seg_byte4,
	output logic [7:0]         seg_byte5,
	output logic [7:0]         blink_command,
	input  logic               cfg_wen,
	input  logic               cfg_wdata
);

	logic display_disabled_q;
	logic f_valid, f_ready;
	cmd_t f_cmd;
	logic q_valid, q_take;
	cmd_t q_cmd;
	res_t res;

	// Hold the enable register; the user must write it only while the block is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_disabled_q <= 1'b0;
		end else if (cfg_wen) begin
			display_disabled_q <= cfg_wdata;
		end
	end

	// Classify the command and build digit bytes.
	slcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.number    (number),
		.unit_code (unit_code),
		.flag      (flag),
		.face      (face),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	// Decouple the front end from the frame engine.
	slcd_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (f_valid),
		.wr_data  (f_cmd),
		.wr_ready (f_ready),
		.rd_en    (q_take),
		.rd_valid (q_valid),
		.rd_data  (q_cmd)
	);

	// Apply the command to the frame and queue any sent frame.
	slcd_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.display_disabled (display_disabled_q),
		.cmd_valid        (q_valid),
		.cmd_take         (q_take),
		.cmd              (q_cmd),
		.res_empty        (empty),
		.res_pop          (pop),
		.res              (res)
	);

	assign seg_byte0     = res.frame[0];
	assign seg_byte1     = res.frame[1];
	assign seg_byte2     = res.frame[2];
	assign seg_byte3     = res.frame[3];
	assign seg_byte4     = res.frame[4];
	assign seg_byte5     = res.frame[5];
	assign blink_command = res.blink;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for segment_lcd_frame_composer: sends mode commands, predicts
// the frames that refreshes emit and checks them in order. Depends on slcd_pkg and the RTL.
module testbench;
	import slcd_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 8;
	localparam int MAX_GAP       = 8;
	localparam int HOLD_CYCLES   = 120;
	// A push passes the front stages and the command queue before it reaches the frame engine.
	localparam int SETTLE_CYCLES = 20;
	localparam int STALL_LIMIT   = 1000;
	localparam int REPORT_LIMIT  = 10;
	localparam logic [3:0] FIRST_SPARE_MODE = MODE_REFRESH + 4'd1;
	localparam logic [3:0] LAST_SPARE_MODE  = 4'hF;

	// Predicts the working frame, the shown frame and the blink byte, and holds the
	// frames that refreshes will send, oldest first.
	class frame_scoreboard;
		logic [7:0] work_bytes[FRAME_BYTES];
		logic [7:0] shown_bytes[FRAME_BYTES];
		logic [7:0] blink_next;
		bit         panel_off;
		res_t       frames_due[$];
		int         commands;
		int         frames_checked;
		int         mismatches;
		int         mode_hits[16];

		function void clear();
			foreach (work_bytes[i]) begin
				work_bytes[i] = 8'hFF;
				shown_bytes[i] = 8'h00;
			end
			blink_next = 8'h00;
			panel_off = 1'b0;
		endfunction

		function int pending();
			return frames_due.size();
		endfunction

		function logic [7:0] digit_segments(int d);
			case (d)
				0: return 8'hF5;
				1: return 8'h05;
				2: return 8'hD3;
				3: return 8'h97;
				4: return 8'h27;
				5: return 8'hB6;
				6: return 8'hF6;
				7: return 8'h15;
				8: return 8'hF7;
				default: return 8'hB7;
			endcase
		endfunction

		function void set_unit(logic [2:0] u);
			work_bytes[3] = work_bytes[3] & 8'h3F;
			work_bytes[3][6] = u[0];
			work_bytes[3][7] = u[1];
			work_bytes[2][3] = u[2];
		endfunction

		function void show_big(int v, logic [2:0] u);
			int mag;
			work_bytes[2] = 8'h00;
			set_unit(u);
			if (v > 19995) begin
				work_bytes[0] = SYM_H;
				work_bytes[1] = SYM_I;
				return;
			end
			if (v < -995) begin
				work_bytes[0] = SYM_L;
				work_bytes[1] = SYM_O;
				return;
			end
			work_bytes[0] = 8'h00;
			work_bytes[5] = 8'h00;
			mag = (v < 0) ? -v : v;
			// Outside the point range round the magnitude half away from zero to units.
			if (v > 1999 || v < -99) begin
				mag = (mag + 5) / 10;
				work_bytes[1] = 8'h00;
			end else begin
				work_bytes[1] = SEG_POINT;
			end
			if (v < 0 && mag != 0)
				work_bytes[0] = SEG_MINUS;
			if (mag > 999)
				work_bytes[0] |= SEG_ONE;
			if (mag > 99)
				work_bytes[0] |= digit_segments((mag / 100) % 10);
			work_bytes[1] |= (mag > 9) ? digit_segments((mag / 10) % 10) : DIGIT_ZERO;
			work_bytes[2] |= digit_segments(mag % 10);
		endfunction

		function void show_small(int v, logic pct);
			int mag;
			work_bytes[4] = work_bytes[4] & 8'h08;
			work_bytes[5] = pct ? 8'h08 : 8'h00;
			if (v > 99) begin
				work_bytes[4] |= SYM_H;
				work_bytes[5] |= SYM_I;
			end else if (v < -9) begin
				work_bytes[4] |= SYM_L;
				work_bytes[5] |= SYM_O;
			end else begin
				if (v < 0)
					work_bytes[4] |= SEG_MINUS;
				mag = (v < 0) ? -v : v;
				if (mag > 9)
					work_bytes[4] |= digit_segments((mag / 10) % 10);
				work_bytes[5] |= digit_segments(mag % 10);
			end
		endfunction

		// Send only when the panel is on and the frame changed; a silent refresh keeps the blink byte.
		function void refresh_panel();
			res_t sent;
			bit   same;
			same = 1'b1;
			foreach (work_bytes[i])
				if (work_bytes[i] != shown_bytes[i])
					same = 1'b0;
			if (panel_off || same)
				return;
			foreach (work_bytes[i]) begin
				shown_bytes[i] = work_bytes[i];
				sent.frame[i] = work_bytes[i];
			end
			sent.blink = blink_next;
			frames_due.push_back(sent);
			if (blink_next != 8'h00)
				blink_next = (blink_next > BLINK_OFF) ? BLINK_OFF : 8'h00;
		endfunction

		function void note_command(logic [3:0] m, logic signed [15:0] n, logic [2:0] u,
				logic f, logic [2:0] fc);
			int v;
			v = int'(n);
			commands++;
			mode_hits[m]++;
			case (m)
				MODE_BIG: show_big(v, u);
				MODE_SMALL: show_small(v, f);
				MODE_UNIT: set_unit(u);
				MODE_FACE: work_bytes[3] = (work_bytes[3] & 8'hEC) | {3'b000, fc[2], 2'b00, fc[1:0]};
				MODE_RADIO: work_bytes[4][3] = f;
				MODE_BATTERY: work_bytes[3][5] = f;
				MODE_ERROR: begin
					work_bytes[0] = SYM_E;
					work_bytes[1] = SYM_E;
					work_bytes[2] = 8'h00;
					work_bytes[3] = work_bytes[3] & 8'h20;
					work_bytes[4] = (work_bytes[4] & 8'h08) | SYM_E;
					work_bytes[5] = SYM_E;
				end
				MODE_OTA: begin
					work_bytes[0] = SYM_O;
					work_bytes[1] = SYM_T;
					work_bytes[2] = SYM_A;
					work_bytes[3] = work_bytes[3] & 8'h20;
					work_bytes[4] = 8'h08;
					work_bytes[5] = 8'h00;
					blink_next = BLINK_FLASH;
					refresh_panel();
				end
				MODE_RESET: begin
					work_bytes[0] = SYM_O;
					work_bytes[1] = SYM_O;
					work_bytes[2] = SYM_O;
					work_bytes[3] = work_bytes[3] & 8'h20;
					work_bytes[4] = work_bytes[4] & 8'h08;
					work_bytes[5] = 8'h00;
					blink_next = BLINK_FLASH;
					refresh_panel();
				end
				MODE_REFRESH: refresh_panel();
				default: ;
			endcase
		endfunction

		function void report(string what);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("MISMATCH %s", what);
		endfunction

		function void check_frame(res_t got);
			res_t want;
			if (frames_due.size() == 0) begin
				report($sformatf("frame %h sent with nothing expected", got));
				return;
			end
			want = frames_due.pop_front();
			frames_checked++;
			for (int i = 0; i < FRAME_BYTES; i++)
				if (got.frame[i] !== want.frame[i])
					report($sformatf("frame %0d seg_byte%0d: expected %h, got %h",
						frames_checked, i, want.frame[i], got.frame[i]));
			if (got.blink !== want.blink)
				report($sformatf("frame %0d blink_command: expected %h, got %h",
					frames_checked, want.blink, got.blink));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [3:0]         mode;
	logic signed [15:0] number;
	logic [2:0]         unit_code;
	logic               flag;
	logic [2:0]         face;
	logic               empty;
	logic               pop;
	logic [7:0]         seg_byte0;
	logic [7:0]         seg_byte1;
	logic [7:0]         seg_byte2;
	logic [7:0]         seg_byte3;
	logic [7:0]         seg_byte4;
	logic [7:0]         seg_byte5;
	logic [7:0]         blink_command;
	logic               cfg_wen;
	logic               cfg_wdata;

	frame_scoreboard sb;
	bit tx_steady;
	bit rx_steady;
	bit hold_request;
	int holds_done;
	int panel_writes;
	int quiet_cycles;

	// Boundary values around the Hi/Lo limits, the point range and the rounding edges.
	int big_edges[25] = '{19995, 19996, 19994, -995, -996, -994, 1999, 2000, -99, -100,
		-1, 0, 1, -5, -4, 5, 9, 10, 99, 100, 999, 1000, 9999, -32768, 32767};
	int small_edges[8] = '{99, 100, -9, -10, 0, 9, 10, -1};

	segment_lcd_frame_composer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.mode          (mode),
		.number        (number),
		.unit_code     (unit_code),
		.flag          (flag),
		.face          (face),
		.empty         (empty),
		.pop           (pop),
		.seg_byte0     (seg_byte0),
		.seg_byte1     (seg_byte1),
		.seg_byte2     (seg_byte2),
		.seg_byte3     (seg_byte3),
		.seg_byte4     (seg_byte4),
		.seg_byte5     (seg_byte5),
		.blink_command (blink_command),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Edge values of each mode, values across its range, and sometimes any 16-bit value.
	function automatic logic signed [15:0] pick_number(logic [3:0] m);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 2)
			return 16'($urandom_range(0, 16'hFFFF));
		if (pick < 4)
			return (m == MODE_SMALL) ? 16'(small_edges[$urandom_range(0, 7)])
				: 16'(big_edges[$urandom_range(0, 24)]);
		if (m == MODE_SMALL)
			return 16'(int'($urandom_range(0, 124)) - 15);
		return 16'(int'($urandom_range(0, 21200)) - 1100);
	endfunction

	// Offer one command after a random gap, or none while tx_steady, and hold it until the block takes it.
	// Leave push high afterwards so back-to-back transactions need no extra edge.
	task automatic send_cmd(input logic [3:0] m, input logic signed [15:0] n,
			input logic [2:0] u, input logic f, input logic [2:0] fc);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		mode <= m;
		number <= n;
		unit_code <= u;
		flag <= f;
		face <= fc;
		do @(posedge clk); while (full);
		sb.note_command(m, n, u, f, fc);
	endtask

	task automatic send_random();
		int pick;
		logic [3:0] m;
		pick = $urandom_range(0, 99);
		if (pick < 32)
			m = MODE_REFRESH;
		else if (pick < 54)
			m = MODE_BIG;
		else if (pick < 68)
			m = MODE_SMALL;
		else if (pick < 73)
			m = MODE_UNIT;
		else if (pick < 78)
			m = MODE_FACE;
		else if (pick < 82)
			m = MODE_RADIO;
		else if (pick < 86)
			m = MODE_BATTERY;
		else if (pick < 90)
			m = MODE_ERROR;
		else if (pick < 93)
			m = MODE_OTA;
		else if (pick < 96)
			m = MODE_RESET;
		else
			m = 4'($urandom_range(FIRST_SPARE_MODE, LAST_SPARE_MODE));
		send_cmd(m, pick_number(m), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
			3'($urandom_range(0, 7)));
	endtask

	// Drop push, wait for every predicted frame, then let silent commands drain out.
	task automatic drain_frames();
		push <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called with the block idle; the prediction takes the new value at once.
	task automatic write_panel_off(input bit off);
		cfg_wen <= 1'b1;
		cfg_wdata <= off;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.panel_off = off;
		panel_writes++;
	endtask

	task automatic run_directed();
		send_cmd(MODE_REFRESH, 16'sd0, 3'd0, 1'b0, 3'd0);      // reset frame differs from shown
		send_cmd(MODE_BIG, 16'sd32767, 3'd7, 1'b0, 3'd0);      // Hi
		send_cmd(MODE_REFRESH, 16'sd0, 3'd0, 1'b0, 3'd0);
		send_cmd(MODE_BIG, -16'sd32768, 3'd0, 1'b1, 3'd7);     // Lo
		send_cmd(MODE_REFRESH, 16'sd0, 3'd0, 1'b0, 3'd0);
		send_cmd(MODE_BIG, 16'sd19995, 3'd5, 1'b0, 3'd0);      // rounds up to 2000
		send_cmd(MODE_REFRESH, 16'sd0, 3'd0, 1'b0, 3'd0);
		send_cmd(MODE_BIG, -16'sd995, 3'd2, 1'b0, 3'd0);       // rounds to -100
		send_cmd(MODE_REFRESH, 16'sd0, 3'd0, 1'b0, 3'd0);
		send_cmd(MODE_BIG, -16'sd99, 3'd1, 1'b0, 3'd0);        // lowest value with a point
		send_cmd(MODE_SMALL, 16'sd99, 3'd0, 1'b1, 3'd0);
		send_cmd(MODE_REFRESH, 16'sd0, 3'd0, 1'b0, 3'd0);
		send_cmd(MODE_SMALL, -16'sd10, 3'd0, 1'b0, 3'd0);      // small Lo
		send_cmd(MODE_UNIT, 16'sd0, 3'd3, 1'b0, 3'd0);
		send_cmd(MODE_FACE, 16'sd0, 3'd0, 1'b0, 3'd7);
		send_cmd(MODE_RADIO, 16'sd0, 3'd0, 1'b1, 3'd0);
		send_cmd(MODE_BATTERY, 16'sd0, 3'd0, 1'b1, 3'd0);
		send_cmd(MODE_REFRESH, 16'sd0, 3'd0, 1'b0, 3'd0);
		send_cmd(MODE_REFRESH, 16'sd0, 3'd0, 1'b0, 3'd0);      // unchanged frame stays silent
		send_cmd(MODE_ERROR, 16'sd0, 3'd0, 1'b0, 3'd0);
		send_cmd(MODE_REFRESH, 16'sd0, 3'd0, 1'b0, 3'd0);
		send_cmd(MODE_OTA, 16'sd0, 3'd0, 1'b0, 3'd0);          // sends with the flash blink
		send_cmd(MODE_REFRESH, 16'sd0, 3'd0, 1'b0, 3'd0);      // silent, keeps the blink-off byte
		send_cmd(MODE_BIG, 16'sd0, 3'd4, 1'b0, 3'd0);
		send_cmd(MODE_REFRESH, 16'sd0, 3'd0, 1'b0, 3'd0);      // carries the blink-off byte
		send_cmd(LAST_SPARE_MODE, -16'sd1, 3'd7, 1'b1, 3'd7);  // spare code does nothing
		send_cmd(MODE_RESET, 16'sd0, 3'd0, 1'b0, 3'd0);
	endtask

	task automatic run_random(input int count);
		for (int k = 0; k < count; k++) begin
			// Every fiftieth command decide whether the next stretch runs without gaps.
			if (k % 50 == 0)
				tx_steady = ($urandom_range(0, 3) == 0);
			send_random();
		end
		tx_steady = 1'b0;
	endtask

	// Keep feeding frame-producing pairs at full rate while the receiver holds off,
	// so both internal queues fill and full must stall the sender.
	task automatic flood_while_blocked();
		hold_request = 1'b1;
		tx_steady = 1'b1;
		for (int k = 0; k < 24; k++) begin
			send_cmd(MODE_BIG, pick_number(MODE_BIG), 3'($urandom_range(0, 7)), 1'b0, 3'd0);
			send_cmd(MODE_REFRESH, 16'sd0, 3'd0, 1'b0, 3'd0);
		end
		tx_steady = 1'b0;
	endtask

	// Receiver: stall a random number of cycles before each transaction, or the long
	// hold when asked, then check the frame at the edge that pops it.
	initial begin : frame_sink
		int   stall;
		int   taken;
		res_t got;
		taken = 0;
		@(posedge arst_n);
		forever begin
			if (taken % 50 == 0)
				rx_steady = ($urandom_range(0, 3) == 0);
			if (hold_request) begin
				stall = HOLD_CYCLES;
				hold_request = 1'b0;
				holds_done++;
			end else begin
				stall = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			got.frame = {seg_byte5, seg_byte4, seg_byte3, seg_byte2, seg_byte1, seg_byte0};
			got.blink = blink_command;
			sb.check_frame(got);
			taken++;
		end
	end

	// Watchdog: end the run when no transaction moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles, %0d frames outstanding",
				STALL_LIMIT, sb.pending());
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		sb = new();
		sb.clear();
		arst_n <= 1'b0;
		push <= 1'b0;
		mode <= MODE_REFRESH;
		number <= 16'sd0;
		unit_code <= 3'd0;
		flag <= 1'b0;
		face <= 3'd0;
		pop <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_wdata <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_panel_off(1'b0);
		run_directed();
		drain_frames();
		run_random(300);
		// Sender pause: nothing more goes in until every predicted frame is back.
		drain_frames();
		run_random(150);
		flood_while_blocked();
		drain_frames();
		// Panel off: refreshes stay silent, but ota and reset screens still arm the blink.
		write_panel_off(1'b1);
		run_random(200);
		drain_frames();
		write_panel_off(1'b0);
		run_random(450);
		drain_frames();

		$display("Covered %0d commands (%0d refreshes) and checked %0d sent frames;",
			sb.commands, sb.mode_hits[MODE_REFRESH], sb.frames_checked);
		$display("display enable written %0d times, receiver held off %0d time(s), %0d mismatches.",
			panel_writes, holds_done, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/slcd_pkg.sv
sv/slcd_front.sv
sv/slcd_cmd_fifo.sv
sv/slcd_back.sv
sv/segment_lcd_frame_composer.sv
sim/testbench.sv
